// File: hdl/lcd_bar_graph_renderer_unit_macros.svh
// assertion shorthands shared by the checker
`ifndef LCD_BAR_GRAPH_RENDERER_UNIT_MACROS_SVH
`define LCD_BAR_GRAPH_RENDERER_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define LBG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lbg_pkg.sv
package lbg_pkg;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] full_scale;
		logic       show_percent;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] column;
		logic [7:0] code;
		logic       last;
	} out_item_t;

	// widths sized for the largest bar and cell the design supports
	localparam int CNT_W  = 6;
	localparam int PART_W = 3;
	localparam int DIV_W  = 15;
	localparam int PCT_QW = 7;
	localparam int COL_W  = 4;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_CURSOR = 1'b1;

	localparam logic [7:0] PCT_FULL   = 8'd100;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_ONE  = 8'h31;
	localparam logic [7:0] ASCII_PCT  = 8'h25;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic              at_full;
		logic              show_pct;
		logic [CNT_W-1:0]  full_cells;
		logic [PART_W-1:0] partial;
		logic [3:0]        tens;
		logic [3:0]        ones;
	} bar_desc_t;

endpackage

// File: hdl/lcd_bar_graph_renderer_unit.sv
// Each accepted item turns into one run of character-LCD writes: a cursor move to
// column 0, CELLS_IN_BAR bar cells (plus a blank cell when the bar is full), then
// the optional percent text. A run is CELLS_IN_BAR+1 to CELLS_IN_BAR+7 beats long
// (17 to 23 at the defaults), the final beat marked by last. The back end puts out
// one beat per cycle while out_ready is high, with no gap between runs while the
// next item waits in the queue, so the output port paces a steady stream.
// The front end works each item through a bit-serial divider, in a bar step and a
// pixel step and, when the percent text is wanted, a percent step; an item at full
// scale skips the divider. It works ahead of the back end through a two-entry
// queue, stalling only while that queue is full.
module lcd_bar_graph_renderer_unit
	import lbg_pkg::*;
#(
	parameter int CELLS_IN_BAR    = 16,
	parameter int PIXELS_PER_CELL = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      push_valid;
	logic      push_ready;
	bar_desc_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	bar_desc_t pop_data;

	lbg_front #(
		.CELLS_IN_BAR    (CELLS_IN_BAR),
		.PIXELS_PER_CELL (PIXELS_PER_CELL)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lbg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lbg_back #(
		.CELLS_IN_BAR    (CELLS_IN_BAR),
		.PIXELS_PER_CELL (PIXELS_PER_CELL)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hdl/lbg_front.sv
module lbg_front
	import lbg_pkg::*;
#(
	parameter int CELLS_IN_BAR    = 16,
	parameter int PIXELS_PER_CELL = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      push_valid,
	input  logic      push_ready,
	output bar_desc_t push_data
);

	localparam int BAR_QW = $clog2(CELLS_IN_BAR);
	localparam int PIX_QW = $clog2(PIXELS_PER_CELL);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BAR  = 3'd1;
	localparam logic [2:0] ST_PIX  = 3'd2;
	localparam logic [2:0] ST_PCT  = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	// divide by ten as multiply and shift, exact below 128
	localparam logic [15:0] RECIP_TEN   = 16'd205;
	localparam int          RECIP_SHIFT = 11;

	logic [2:0]        state_q;
	logic [7:0]        value_q;
	logic [7:0]        fs_q;
	logic              pct_q;
	logic              at_full_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [PCT_QW-1:0] quo_q;
	logic [2:0]        step_q;
	logic [CNT_W-1:0]  full_q;
	logic [PART_W-1:0] part_q;

	logic              ge;
	logic [DIV_W-1:0]  rem_nx;
	logic [PCT_QW-1:0] quo_nx;
	logic              step_done;
	logic [7:0]        v_cl;
	logic [15:0]       tens_prod;
	logic [3:0]        tens;
	logic [3:0]        ones;

	assign ge        = rem_q >= den_q;
	assign rem_nx    = ge ? rem_q - den_q : rem_q;
	assign quo_nx    = {quo_q[PCT_QW-2:0], ge};
	assign step_done = step_q == 3'd0;
	assign v_cl      = (in_data.value > in_data.full_scale) ? in_data.full_scale : in_data.value;

	assign tens_prod = (16'(quo_q) * RECIP_TEN) >> RECIP_SHIFT;
	assign tens      = tens_prod[3:0];
	assign ones      = 4'(quo_q - 7'(tens) * 7'd10);

	assign in_ready   = state_q == ST_IDLE;
	assign push_valid = state_q == ST_PUSH;

	always_comb begin
		push_data.at_full    = at_full_q;
		push_data.show_pct   = pct_q;
		push_data.full_cells = full_q;
		push_data.partial    = part_q;
		push_data.tens       = tens;
		push_data.ones       = ones;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (v_cl == in_data.full_scale) ? ST_PUSH : ST_BAR;
					end
				end
				ST_BAR: begin
					if (step_done) begin
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					if (step_done) begin
						state_q <= pct_q ? ST_PCT : ST_PUSH;
					end
				end
				ST_PCT: begin
					if (step_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				value_q   <= v_cl;
				fs_q      <= in_data.full_scale;
				pct_q     <= in_data.show_percent;
				at_full_q <= v_cl == in_data.full_scale;
				rem_q     <= DIV_W'(int'(v_cl) * CELLS_IN_BAR);
				den_q     <= DIV_W'(int'(in_data.full_scale) << (BAR_QW - 1));
				step_q    <= 3'(BAR_QW - 1);
				quo_q     <= '0;
			end
			ST_BAR: begin
				rem_q  <= rem_nx;
				den_q  <= den_q >> 1;
				quo_q  <= quo_nx;
				step_q <= step_q - 3'd1;
				if (step_done) begin
					full_q <= CNT_W'(quo_nx);
					rem_q  <= DIV_W'(int'(rem_nx[7:0]) * PIXELS_PER_CELL);
					den_q  <= DIV_W'(int'(fs_q) << (PIX_QW - 1));
					step_q <= 3'(PIX_QW - 1);
					quo_q  <= '0;
				end
			end
			ST_PIX: begin
				rem_q  <= rem_nx;
				den_q  <= den_q >> 1;
				quo_q  <= quo_nx;
				step_q <= step_q - 3'd1;
				if (step_done) begin
					part_q <= PART_W'(quo_nx);
					rem_q  <= DIV_W'(int'(value_q) * int'(PCT_FULL));
					den_q  <= DIV_W'(int'(fs_q) << (PCT_QW - 1));
					step_q <= 3'(PCT_QW - 1);
					quo_q  <= '0;
				end
			end
			ST_PCT: begin
				rem_q  <= rem_nx;
				den_q  <= den_q >> 1;
				quo_q  <= quo_nx;
				step_q <= step_q - 3'd1;
			end
			ST_PUSH: begin
				quo_q <= quo_q;
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

endmodule

// File: hdl/lbg_queue.sv
module lbg_queue
	import lbg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  bar_desc_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output bar_desc_t pop_data
);

	bar_desc_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers wrap on their own, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/lbg_back.sv
module lbg_back
	import lbg_pkg::*;
#(
	parameter int CELLS_IN_BAR    = 16,
	parameter int PIXELS_PER_CELL = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  bar_desc_t pop_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int POS_W = $clog2(CELLS_IN_BAR + 8);

	localparam logic [POS_W-1:0] POS_BAR_END   = POS_W'(CELLS_IN_BAR);
	localparam logic [POS_W-1:0] POS_EXTRA     = POS_W'(CELLS_IN_BAR + 1);
	localparam logic [POS_W-1:0] POS_PCT_FULL  = POS_W'(CELLS_IN_BAR + 2);
	localparam logic [POS_W-1:0] POS_PCT_PART  = POS_W'(CELLS_IN_BAR + 1);
	localparam logic [POS_W-1:0] LAST_FULL_PCT = POS_W'(CELLS_IN_BAR + 6);
	localparam logic [POS_W-1:0] LAST_PART_PCT = POS_W'(CELLS_IN_BAR + 3);
	localparam logic [7:0]       CODE_FULL     = 8'(PIXELS_PER_CELL);
	localparam logic [COL_W-1:0] COL_LAST      = COL_W'(CELLS_IN_BAR - 1);

	logic             busy_q;
	bar_desc_t        desc_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	out_item_t        out_q;

	out_item_t        wr;
	logic [POS_W-1:0] cell_idx;
	logic [POS_W-1:0] pct_pos;
	logic [2:0]       pct_idx;
	logic [POS_W-1:0] last_pos;
	logic             emit;

	assign cell_idx = pos_q - POS_W'(1);
	assign pct_pos  = pos_q - (desc_q.at_full ? POS_PCT_FULL : POS_PCT_PART);
	assign pct_idx  = pct_pos[2:0];

	always_comb begin
		priority if (desc_q.at_full && desc_q.show_pct) begin
			last_pos = LAST_FULL_PCT;
		end else if (desc_q.at_full) begin
			last_pos = POS_EXTRA;
		end else if (desc_q.show_pct) begin
			last_pos = LAST_PART_PCT;
		end else begin
			last_pos = POS_BAR_END;
		end
	end

	always_comb begin
		wr.kind   = KIND_DATA;
		wr.column = '0;
		wr.code   = '0;
		wr.last   = pos_q == last_pos;
		priority if (pos_q == '0) begin
			wr.kind = KIND_CURSOR;
		end else if (pos_q <= POS_BAR_END) begin
			if (desc_q.at_full || 8'(cell_idx) < 8'(desc_q.full_cells)) begin
				wr.code = CODE_FULL;
			end else if (8'(cell_idx) == 8'(desc_q.full_cells)) begin
				wr.code = 8'(desc_q.partial);
			end
		end else if (desc_q.at_full && pos_q == POS_EXTRA) begin
			// the cell past the bar stays blank when full
			wr.code = '0;
		end else if (desc_q.at_full) begin
			unique case (pct_idx)
				3'd0: begin
					wr.kind   = KIND_CURSOR;
					wr.column = COL_LAST;
				end
				3'd1:    wr.code = ASCII_ONE;
				3'd2:    wr.code = ASCII_ZERO;
				3'd3:    wr.code = ASCII_ZERO;
				default: wr.code = ASCII_PCT;
			endcase
		end else begin
			unique case (pct_idx)
				3'd0:    wr.code = ASCII_ZERO + 8'(desc_q.tens);
				3'd1:    wr.code = ASCII_ZERO + 8'(desc_q.ones);
				default: wr.code = ASCII_PCT;
			endcase
		end
	end

	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign pop_ready = !busy_q || (emit && wr.last);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (emit) begin
				pos_q <= pos_q + POS_W'(1);
				if (wr.last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			desc_q <= pop_data;
		end
		if (emit) begin
			out_q <= wr;
		end
	end

endmodule

// File: hdl/lbg_chk.sv
`include "lcd_bar_graph_renderer_unit_macros.svh"

module lbg_chk
	import lbg_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// high while the next output beat opens a run
	logic start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			start_q <= out_data.last;
		end
	end

	`LBG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
	`LBG_ASSERT_NOW(a_cursor_code, out_valid && out_data.kind == KIND_CURSOR, out_data.code == 8'd0, "cursor move carries a code")
	`LBG_ASSERT_NOW(a_data_column, out_valid && out_data.kind == KIND_DATA, out_data.column == 4'd0, "data write carries a column")
	`LBG_ASSERT_NOW(a_run_start, out_valid && start_q, out_data.kind == KIND_CURSOR && out_data.column == 4'd0, "run does not open with a home cursor move")
	`LBG_ASSERT_NOW(a_in_known, in_valid && in_ready, !$isunknown(in_data), "accepted input beat has unknown bits")

endmodule

bind lcd_bar_graph_renderer_unit lbg_chk u_lbg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
